// File: sv/crc16r_pkg.sv
package crc16r_pkg;

  // CRC-16/ARC: reflected polynomial, zero initial value, no final inversion.
  localparam logic [15:0] CrcPoly = 16'hA001;
  localparam logic [15:0] CrcInit = 16'h0000;

  typedef enum logic [1:0] {
    StAccepted = 2'd0,
    StMismatch = 2'd1,
    StReadErr  = 2'd2
  } status_e;

endpackage

// File: sv/crc16r_if.sv
interface crc16r_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       read_error;

  modport source (output valid, output data_byte, output read_error, input ready);
  modport sink   (input valid, input data_byte, input read_error, output ready);
endinterface

interface crc16r_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] channel_number;

  modport source (output valid, output status, output channel_number, input ready);
  modport sink   (input valid, input status, input channel_number, output ready);
endinterface

// File: sv/crc16r_crc_update.sv
module crc16r_crc_update (
  input  logic [15:0] crc_i,
  input  logic [7:0]  data_i,
  output logic [15:0] crc_o
);

  // The eight bit steps of one byte are unrolled into a single combinational path.
  always_comb begin
    logic [15:0] c;
    c = crc_i ^ {8'h00, data_i};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ crc16r_pkg::CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    crc_o = c;
  end

endmodule

// File: sv/crc16_channel_packet_receiver.sv
// Packet receiver for four-byte programming packets (channel high, channel low,
// CRC high, CRC low) checked with CRC-16/ARC over the two channel bytes. One byte
// request is taken every cycle while ready is high; ready is high whenever the
// result register is empty or its result is being taken in the same cycle. The
// result of a packet, or of a byte flagged as a read error, appears in the result
// register in the cycle after the request that ends it; a read error restarts the
// packet at byte one. Cycle time is set by the unrolled eight-step CRC byte update.
module crc16_channel_packet_receiver (
  input  logic               clk_i,
  input  logic               rst_ni,
  crc16r_in_if.sink          in_i,
  crc16r_out_if.source       out_o
);

  typedef enum logic [1:0] {
    PosChanHi = 2'd0,
    PosChanLo = 2'd1,
    PosCrcHi  = 2'd2,
    PosCrcLo  = 2'd3
  } pos_e;

  pos_e        pos_q, pos_d;
  logic [15:0] crc_q, crc_d;
  logic [15:0] chan_q, chan_d;
  logic [7:0]  crc_hi_q, crc_hi_d;

  logic                  out_valid_q, out_valid_d;
  crc16r_pkg::status_e   status_q, status_d;
  logic [15:0]           chan_out_q, chan_out_d;

  logic        accept;
  logic        result;
  logic [15:0] crc_seed;
  logic [15:0] crc_next;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  assign crc_seed = (pos_q == PosChanHi) ? crc16r_pkg::CrcInit : crc_q;

  crc16r_crc_update u_crc (
    .crc_i  (crc_seed),
    .data_i (in_i.data_byte),
    .crc_o  (crc_next)
  );

  always_comb begin
    pos_d      = pos_q;
    crc_d      = crc_q;
    chan_d     = chan_q;
    crc_hi_d   = crc_hi_q;
    result     = 1'b0;
    status_d   = status_q;
    chan_out_d = chan_out_q;
    if (accept) begin
      if (in_i.read_error) begin
        pos_d      = PosChanHi;
        crc_d      = crc16r_pkg::CrcInit;
        chan_d     = 16'h0000;
        crc_hi_d   = 8'h00;
        result     = 1'b1;
        status_d   = crc16r_pkg::StReadErr;
        chan_out_d = 16'h0000;
      end else begin
        unique case (pos_q)
          PosChanHi: begin
            crc_d  = crc_next;
            chan_d = {in_i.data_byte, 8'h00};
            pos_d  = PosChanLo;
          end
          PosChanLo: begin
            crc_d  = crc_next;
            chan_d = {chan_q[15:8], in_i.data_byte};
            pos_d  = PosCrcHi;
          end
          PosCrcHi: begin
            crc_hi_d = in_i.data_byte;
            pos_d    = PosCrcLo;
          end
          PosCrcLo: begin
            result = 1'b1;
            if ({crc_hi_q, in_i.data_byte} == crc_q) begin
              status_d   = crc16r_pkg::StAccepted;
              chan_out_d = chan_q;
            end else begin
              status_d   = crc16r_pkg::StMismatch;
              chan_out_d = 16'h0000;
            end
            pos_d    = PosChanHi;
            crc_d    = crc16r_pkg::CrcInit;
            chan_d   = 16'h0000;
            crc_hi_d = 8'h00;
          end
          default: begin
            pos_d = PosChanHi;
          end
        endcase
      end
    end
    if (result) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= PosChanHi;
      crc_q       <= crc16r_pkg::CrcInit;
      chan_q      <= 16'h0000;
      crc_hi_q    <= 8'h00;
      out_valid_q <= 1'b0;
      status_q    <= crc16r_pkg::StAccepted;
      chan_out_q  <= 16'h0000;
    end else begin
      pos_q       <= pos_d;
      crc_q       <= crc_d;
      chan_q      <= chan_d;
      crc_hi_q    <= crc_hi_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
      chan_out_q  <= chan_out_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.status         = status_q;
  assign out_o.channel_number = chan_out_q;

endmodule

// File: sv/crc16r_checker.sv
module crc16r_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_read_error_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  out_status_i,
  input logic [15:0] out_channel_number_i
);

  // A result waiting on a stalled sink stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_status_i) && $stable(out_channel_number_i))
    else $error("stalled result changed");

  // A request flagged as a read error gives a read error result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_read_error_i |=>
      out_valid_i && out_status_i == crc16r_pkg::StReadErr)
    else $error("read error not reported");

  // Only an accepted packet carries a channel number.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i != crc16r_pkg::StAccepted |-> out_channel_number_i == 16'h0000)
    else $error("channel number on a failed packet");

  // With the result register empty the block always takes a request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty result register");

endmodule

bind crc16_channel_packet_receiver crc16r_checker u_crc16r_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .in_valid_i           (in_i.valid),
  .in_ready_i           (in_i.ready),
  .in_read_error_i      (in_i.read_error),
  .out_valid_i          (out_o.valid),
  .out_ready_i          (out_o.ready),
  .out_status_i         (out_o.status),
  .out_channel_number_i (out_o.channel_number)
);

// File: test/crc16r_tb_pkg.sv
package crc16r_tb_pkg;

  // Shared by the stimulus, which builds well-formed packets, and by the checker.
  function automatic logic [15:0] crc16_arc_byte(input logic [15:0] crc,
                                                 input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ crc16r_pkg::CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [15:0] channel_crc(input logic [15:0] channel);
    return crc16_arc_byte(crc16_arc_byte(crc16r_pkg::CrcInit, channel[15:8]), channel[7:0]);
  endfunction

endpackage

// File: test/crc16r_packet_checker.sv
module crc16r_packet_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  crc16r_in_if        byte_i,
  crc16r_out_if       result_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef enum logic [1:0] {
    RxChanHi,
    RxChanLo,
    RxCrcHi,
    RxCrcLo
  } rx_pos_e;

  typedef struct packed {
    crc16r_pkg::status_e status;
    logic [15:0]         channel;
  } packet_result_t;

  packet_result_t expected_q[$];

  rx_pos_e     byte_pos;
  logic [15:0] crc_acc;
  logic [15:0] channel_acc;
  logic [7:0]  crc_hi_rx;

  initial fail_count_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin : watch
    packet_result_t want;
    packet_result_t next;
    if (!rst_ni) begin
      expected_q.delete();
      byte_pos    = RxChanHi;
      crc_acc     = crc16r_pkg::CrcInit;
      channel_acc = 16'h0000;
      crc_hi_rx   = 8'h00;
      pending_o  <= 0;
    end else begin
      if (result_i.valid && result_i.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual status %0d channel %h",
                   $time, result_i.status, result_i.channel_number);
          fail_count_o++;
        end else begin
          want = expected_q.pop_front();
          if (result_i.status !== want.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, result_i.status);
            fail_count_o++;
          end
          if (result_i.channel_number !== want.channel) begin
            $display("%0t: channel mismatch: expected %h, actual %h",
                     $time, want.channel, result_i.channel_number);
            fail_count_o++;
          end
        end
      end

      if (byte_i.valid && byte_i.ready) begin
        if (byte_i.read_error) begin
          // A failed byte ends the packet wherever it falls.
          next.status  = crc16r_pkg::StReadErr;
          next.channel = 16'h0000;
          expected_q.push_back(next);
          byte_pos = RxChanHi;
        end else begin
          case (byte_pos)
            RxChanHi: begin
              crc_acc     = crc16r_tb_pkg::crc16_arc_byte(crc16r_pkg::CrcInit,
                                                          byte_i.data_byte);
              channel_acc = {byte_i.data_byte, 8'h00};
              byte_pos    = RxChanLo;
            end
            RxChanLo: begin
              crc_acc          = crc16r_tb_pkg::crc16_arc_byte(crc_acc, byte_i.data_byte);
              channel_acc[7:0] = byte_i.data_byte;
              byte_pos         = RxCrcHi;
            end
            RxCrcHi: begin
              crc_hi_rx = byte_i.data_byte;
              byte_pos  = RxCrcLo;
            end
            default: begin
              if ({crc_hi_rx, byte_i.data_byte} == crc_acc) begin
                next.status  = crc16r_pkg::StAccepted;
                next.channel = channel_acc;
              end else begin
                next.status  = crc16r_pkg::StMismatch;
                next.channel = 16'h0000;
              end
              expected_q.push_back(next);
              byte_pos = RxChanHi;
            end
          endcase
        end
        if (byte_pos == RxChanHi) begin
          crc_acc     = crc16r_pkg::CrcInit;
          channel_acc = 16'h0000;
          crc_hi_rx   = 8'h00;
        end
      end
      pending_o <= expected_q.size();
    end
  end

endmodule

// File: test/tb_crc16_channel_packet_receiver.sv
module tb_crc16_channel_packet_receiver;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned requests_sent = 0;
  bit          send_burst = 1'b0;
  bit          take_burst = 1'b0;

  crc16r_in_if  byte_if ();
  crc16r_out_if result_if ();

  always #5 clk_i = ~clk_i;

  crc16_channel_packet_receiver uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_if),
    .out_o  (result_if)
  );

  crc16r_packet_checker packet_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_i       (byte_if),
    .result_i     (result_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Called at a rising edge; returns at the edge where the request is taken.
  task automatic send_byte(input logic [7:0] data, input logic read_error);
    int unsigned gap;
    if ($urandom_range(0, 15) == 0) send_burst = ~send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      byte_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    byte_if.valid      <= 1'b1;
    byte_if.data_byte  <= data;
    byte_if.read_error <= read_error;
    do @(posedge clk_i); while (!byte_if.ready);
    requests_sent++;
  endtask

  // fail_at names the byte that arrives with a read error, or -1 for none.
  task automatic send_packet(input logic [15:0] channel, input logic [15:0] crc,
                             input int fail_at);
    logic [31:0] packet;
    packet = {channel, crc};
    for (int i = 0; i < 4; i++) begin
      if (i == fail_at) begin
        send_byte(8'($urandom), 1'b1);
        return;
      end
      send_byte(packet[31 - 8*i -: 8], 1'b0);
    end
  endtask

  function automatic logic [7:0] channel_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin
    result_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin : sink
      int unsigned gap;
      if ($urandom_range(0, 15) == 0) take_burst = ~take_burst;
      gap = take_burst ? 0 : $urandom_range(0, 9);
      if (gap != 0) begin
        result_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      result_if.ready <= 1'b1;
      do @(posedge clk_i); while (!result_if.valid);
    end
  end

  initial begin : stimulus
    logic [15:0] channel;
    logic [15:0] crc;
    int          fail_at;
    rst_ni              = 1'b0;
    byte_if.valid      <= 1'b0;
    byte_if.data_byte  <= 8'h00;
    byte_if.read_error <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_packet(16'h0000, crc16r_tb_pkg::channel_crc(16'h0000), -1);
    send_packet(16'hFFFF, crc16r_tb_pkg::channel_crc(16'hFFFF), -1);
    // Wrong CRC, once in the low byte and once in the high byte.
    send_packet(16'h1234, crc16r_tb_pkg::channel_crc(16'h1234) ^ 16'h0001, -1);
    send_packet(16'h8001, crc16r_tb_pkg::channel_crc(16'h8001) ^ 16'h8000, -1);
    for (int k = 0; k < 4; k++) begin
      send_packet(16'hA5C3, crc16r_tb_pkg::channel_crc(16'hA5C3), k);
    end

    while (requests_sent < 900) begin
      if ($urandom_range(0, 9) < 8) begin
        channel = {channel_byte(), channel_byte()};
        crc     = crc16r_tb_pkg::channel_crc(channel);
        if ($urandom_range(0, 3) == 0) crc ^= 16'h0001 << $urandom_range(0, 15);
        if ($urandom_range(0, 15) == 0) crc = 16'($urandom);
        fail_at = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 3)) : -1;
        send_packet(channel, crc, fail_at);
      end else begin
        // Stray bytes knock the packet framing out of step.
        send_byte(8'($urandom), ($urandom_range(0, 3) == 0));
      end
    end
    byte_if.valid <= 1'b0;

    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule
